// ===== hw/rtl/utf8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Item types for the request and response channels, and the decoder state
// and result bundle shared by the top level and the decoder.
// ----------------------------------------------------------------------------
package utf8u16_pkg;

   // One UTF-8 byte of the string, with the end-of-string mark.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_payload_type;

   // One UTF-16 code unit, or a bare end marker.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        run_last;
      logic        output_end;
   } rsp_payload_type;

   // Sequence state carried from one byte to the next. At most two bytes
   // after a lead are ever held: the third completes the sequence at once.
   typedef struct packed {
      logic [7:0] lead_byte;
      logic [1:0] bytes_needed;
      logic [7:0] held_0;
      logic [7:0] held_1;
      logic [1:0] held_count;
   } dec_state_type;

   // Everything the decoder returns for one byte.
   typedef struct packed {
      rsp_payload_type first;
      rsp_payload_type second;
      logic [1:0]      count;
      dec_state_type   next_state;
   } dec_out_type;

   localparam dec_state_type DEC_STATE_IDLE = '{
      lead_byte:    8'h00,
      bytes_needed: 2'd0,
      held_0:       8'h00,
      held_1:       8'h00,
      held_count:   2'd0
   };

endpackage

// ===== hw/rtl/utf8u16_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 byte decoder
// Combinational step: takes one byte and the sequence state, and gives up
// to two code units and the next state, including the end-of-string replay.
// ----------------------------------------------------------------------------
module utf8u16_decoder
   import utf8u16_pkg::*;
(
   input  dec_state_type   state,
   input  req_payload_type item,
   output dec_out_type     result
);

   // Classes of a byte by the number of bytes that follow it as a lead.
   localparam logic [2:0] FOLLOW_NONE  = 3'd0;
   localparam logic [2:0] FOLLOW_ONE   = 3'd1;
   localparam logic [2:0] FOLLOW_TWO   = 3'd2;
   localparam logic [2:0] FOLLOW_THREE = 3'd3;
   localparam logic [2:0] FOLLOW_STRAY = 3'd4;

   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SUPP_BASE      = 21'h10000;

   function automatic logic [2:0] follow_count(input logic [7:0] b);
      logic [2:0] k;
      if (b[7] == 1'b0) begin
         k = FOLLOW_NONE;
      end else if (b[7:5] == 3'b110) begin
         k = FOLLOW_ONE;
      end else if (b[7:4] == 4'b1110) begin
         k = FOLLOW_TWO;
      end else if (b[7:3] == 5'b11110) begin
         k = FOLLOW_THREE;
      end else begin
         k = FOLLOW_STRAY;
      end
      return k;
   endfunction

   function automatic logic [20:0] decode_cp(input logic [7:0] lead, input logic [1:0] n,
                                             input logic [7:0] r0, input logic [7:0] r1,
                                             input logic [7:0] r2);
      logic [20:0] cp;
      if (n == FOLLOW_ONE[1:0]) begin
         cp = {10'd0, lead[4:0], r0[5:0]};
      end else if (n == FOLLOW_TWO[1:0]) begin
         cp = {5'd0, lead[3:0], r0[5:0], r1[5:0]};
      end else begin
         cp = {lead[2:0], r0[5:0], r1[5:0], r2[5:0]};
      end
      return cp;
   endfunction

   always_comb begin
      logic [7:0]    b;
      logic          fin;
      logic [2:0]    k;
      logic [1:0]    new_count;
      logic [7:0]    r0;
      logic [7:0]    r1;
      logic [20:0]   cp;
      logic [20:0]   offs;
      logic [15:0]   u0;
      logic [15:0]   u1;
      logic          valid0;
      logic [1:0]    n_units;
      logic          emit_cp;
      dec_state_type st;

      b         = item.in_byte;
      fin       = item.string_end;
      k         = follow_count(b);
      new_count = state.held_count + 2'd1;
      r0        = (state.held_count == 2'd0) ? b : state.held_0;
      r1        = (state.held_count == 2'd1) ? b : state.held_1;
      cp        = decode_cp(state.lead_byte, state.bytes_needed, r0, r1, b);
      offs      = cp - SUPP_BASE;
      u0        = 16'h0000;
      u1        = 16'h0000;
      valid0    = 1'b1;
      n_units   = 2'd0;
      emit_cp   = 1'b0;
      st        = state;

      if (state.bytes_needed == 2'd0) begin
         if (k == FOLLOW_NONE) begin
            u0      = {8'h00, b};
            n_units = 2'd1;
         end else if (k != FOLLOW_STRAY && !fin) begin
            st.lead_byte    = b;
            st.bytes_needed = k[1:0];
            st.held_count   = 2'd0;
         end
      end else if (new_count >= state.bytes_needed) begin
         emit_cp = 1'b1;
         st      = DEC_STATE_IDLE;
      end else begin
         if (state.held_count == 2'd0) begin
            st.held_0 = b;
         end else begin
            st.held_1 = b;
         end
         st.held_count = new_count;
         // The string ended short: the lead is dropped and the bytes held
         // after it are decoded once more on their own.
         if (fin) begin
            if (new_count == 2'd1) begin
               if (k == FOLLOW_NONE) begin
                  u0      = {8'h00, b};
                  n_units = 2'd1;
               end
            end else begin
               if (follow_count(r0) == FOLLOW_NONE) begin
                  u0      = {8'h00, r0};
                  n_units = 2'd1;
                  if (k == FOLLOW_NONE) begin
                     u1      = {8'h00, b};
                     n_units = 2'd2;
                  end
               end else if (follow_count(r0) == FOLLOW_ONE) begin
                  u0      = {5'd0, r0[4:0], b[5:0]};
                  n_units = 2'd1;
               end else if (k == FOLLOW_NONE) begin
                  u0      = {8'h00, b};
                  n_units = 2'd1;
               end
            end
         end
      end

      if (emit_cp) begin
         if (cp < SUPP_BASE) begin
            u0      = cp[15:0];
            n_units = 2'd1;
         end else begin
            u0      = HIGH_SURR_BASE | {5'd0, offs[20:10]};
            u1      = LOW_SURR_BASE | {6'd0, offs[9:0]};
            n_units = 2'd2;
         end
      end

      if (fin) begin
         st = DEC_STATE_IDLE;
         if (n_units == 2'd0) begin
            u0      = 16'h0000;
            valid0  = 1'b0;
            n_units = 2'd1;
         end
      end

      result.first.code_unit  = u0;
      result.first.unit_valid = valid0;
      result.first.run_last   = (n_units == 2'd1);
      result.first.output_end = fin && (n_units == 2'd1);
      result.second.code_unit  = u1;
      result.second.unit_valid = 1'b1;
      result.second.run_last   = 1'b1;
      result.second.output_end = fin;
      result.count      = n_units;
      result.next_state = st;
   end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder unit
// Turns a UTF-8 byte stream into UTF-16 code units, one byte per item in and
// one code unit per item out, with surrogate pairs for supplementary planes.
//
//   Channel | Direction | Handshake                | Item
//   req     | in        | req_valid / req_stall    | req_payload_type (byte, end)
//   rsp     | out       | rsp_valid / rsp_stall    | rsp_payload_type (unit, flags)
//
// One byte is taken each cycle while the response side is not stalled; a byte
// that yields a surrogate pair or two replayed units holds the input while the
// second unit leaves, since the result register sends one unit per cycle.
// Each byte passes through the input register, then is decoded into the result register.
// Reset clears the sequence state and both registers' valid flags.
// A stalled response stalls the request side only once the input register is
// full and the result register cannot be refilled in the same cycle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
   import utf8u16_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   dec_state_type   state_ff, state_in;
   rsp_payload_type res0_ff, res0_in;
   rsp_payload_type res1_ff, res1_in;
   logic [1:0]      res_cnt_ff, res_cnt_in;

   dec_out_type     dec_out;
   logic            rsp_fire;
   logic            req_fire;
   logic            pair_free;
   logic            consume;

   utf8u16_decoder u_decoder (
      .state  (state_ff),
      .item   (in_data_ff),
      .result (dec_out)
   );

   assign rsp_valid   = (res_cnt_ff != 2'd0);
   assign rsp_payload = res0_ff;
   assign rsp_fire    = rsp_valid && !rsp_stall;

   // The result register can take a new item once its last unit leaves.
   assign pair_free = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_fire);
   assign consume   = in_valid_ff && pair_free;
   assign req_stall = in_valid_ff && !pair_free;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      state_in    = state_ff;
      res0_in     = res0_ff;
      res1_in     = res1_ff;
      res_cnt_in  = res_cnt_ff;

      if (consume) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end

      if (consume) begin
         state_in   = dec_out.next_state;
         res0_in    = dec_out.first;
         res1_in    = dec_out.second;
         res_cnt_in = dec_out.count;
      end else if (rsp_fire) begin
         res0_in    = res1_ff;
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= DEC_STATE_IDLE;
         res_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         res_cnt_ff  <= res_cnt_in;
      end
      in_data_ff <= in_data_in;
      res0_ff    <= res0_in;
      res1_ff    <= res1_in;
   end

endmodule
